// ----- design/rfct_pkg.sv -----
// Shared types, constants and CRC functions of the radio frame check trailer.
`default_nettype none
package rfct_pkg;

   localparam int BYTE_W      = 8;
   localparam int CRC16_W     = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam int BURST_MAX   = 4;
   localparam int QUEUE_DEPTH = 5;
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int BURST_W     = $clog2(BURST_MAX + 1);

   localparam logic [CSR_INDEX_W-1:0] CSR_CRC16_ENABLE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CRC8_ENABLE  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CRC16_OFFSET = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CRC16_INIT   = 2'd3;

   localparam logic                 RESET_CRC16_ENABLE = 1'b1;
   localparam logic                 RESET_CRC8_ENABLE  = 1'b1;
   localparam logic [BYTE_W-1:0]    RESET_CRC16_OFFSET = 8'd10;
   localparam logic [CRC16_W-1:0]   RESET_CRC16_INIT   = 16'hFFFF;

   localparam logic [CRC16_W-1:0]   CRC16_POLY = 16'hA001;
   localparam logic [BYTE_W-1:0]    CRC8_TAPS  = 8'h01;
   localparam logic [BYTE_W-1:0]    BYTE_ZERO  = 8'h00;
   localparam logic [BYTE_W-1:0]    INDEX_MAX  = 8'hFF;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } rfct_entry_type;

   typedef struct packed {
      logic [BURST_W-1:0]                    count;
      rfct_entry_type [BURST_MAX-1:0]        entries;
   } rfct_push_type;

   function automatic logic [CRC16_W-1:0] crc16_byte(input logic [CRC16_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] value);
      logic [CRC16_W-1:0] c;
      c = crc ^ {{(CRC16_W-BYTE_W){1'b0}}, value};
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC16_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] value);
      logic [BYTE_W-1:0] c;
      c = crc ^ value;
      for (int k = 0; k < BYTE_W; k++) begin
         c = {c[BYTE_W-2:0], 1'b0} ^ (c[BYTE_W-1] ? CRC8_TAPS : BYTE_ZERO);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ----- design/radio_frame_crc_trailer.sv -----
// Top level of the radio frame check trailer: CRC state, trailer build and output queue.
// The block takes one body byte per cycle while its input is ready and writes it to a
// registered output queue. The last body byte of a frame yields one to four output bytes
// (body byte, CRC-16 high, CRC-16 low, CRC-8) into the queue. The input is ready whenever
// the five-entry output queue holds at most one byte, which gives one body byte per cycle
// within a frame while the output side keeps taking bytes. Configuration writes take effect
// at once; CRC-16 start value is picked up at the first byte of the next frame.
`default_nettype none
module radio_frame_crc_trailer (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [rfct_pkg::BYTE_W-1:0] req_data_byte,
   input  wire logic                        req_data_last,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [rfct_pkg::BYTE_W-1:0]      rsp_out_byte,
   output logic                             rsp_out_last,
   input  wire logic                        csr_write_enable,
   input  wire logic [rfct_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [rfct_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import rfct_pkg::*;

   logic                crc16_enable_ff;
   logic                crc8_enable_ff;
   logic [BYTE_W-1:0]   crc16_offset_ff;
   logic [CRC16_W-1:0]  crc16_init_ff;

   logic [CRC16_W-1:0]  crc16_accum_ff;
   logic [CRC16_W-1:0]  crc16_accum_in;
   logic [BYTE_W-1:0]   crc8_accum_ff;
   logic [BYTE_W-1:0]   crc8_accum_in;
   logic [BYTE_W-1:0]   byte_index_ff;
   logic [BYTE_W-1:0]   byte_index_in;

   logic                accept;
   logic                first;
   logic [CRC16_W-1:0]  c16_start;
   logic [CRC16_W-1:0]  c16_next;
   logic [BYTE_W-1:0]   c8_start;
   logic [BYTE_W-1:0]   c8_next;
   logic [BYTE_W-1:0]   crc_hi;
   logic [BYTE_W-1:0]   crc_lo;
   logic [BYTE_W-1:0]   c8_final;
   rfct_push_type       push;

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         crc16_enable_ff <= RESET_CRC16_ENABLE;
         crc8_enable_ff  <= RESET_CRC8_ENABLE;
         crc16_offset_ff <= RESET_CRC16_OFFSET;
         crc16_init_ff   <= RESET_CRC16_INIT;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_CRC16_ENABLE: crc16_enable_ff <= csr_write_data[0];
            CSR_CRC8_ENABLE:  crc8_enable_ff  <= csr_write_data[0];
            CSR_CRC16_OFFSET: crc16_offset_ff <= csr_write_data[BYTE_W-1:0];
            CSR_CRC16_INIT:   crc16_init_ff   <= csr_write_data[CRC16_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      first     = (byte_index_ff == '0);
      c16_start = first ? crc16_init_ff : crc16_accum_ff;
      c8_start  = first ? BYTE_ZERO : crc8_accum_ff;
      c16_next  = (byte_index_ff >= crc16_offset_ff) ? crc16_byte(c16_start, req_data_byte)
                                                     : c16_start;
      c8_next   = crc8_byte(c8_start, req_data_byte);
      crc_hi    = c16_next[CRC16_W-1:BYTE_W];
      crc_lo    = c16_next[BYTE_W-1:0];
      c8_final  = crc8_byte(crc8_byte(c8_next, crc_hi), crc_lo);

      push.count   = '0;
      push.entries = '0;
      push.entries[0].data = req_data_byte;
      if (!req_data_last) begin
         push.count = BURST_W'(1);
      end else if (!crc16_enable_ff && !crc8_enable_ff) begin
         push.count = BURST_W'(1);
         push.entries[0].last = 1'b1;
      end else if (!crc16_enable_ff) begin
         push.count = BURST_W'(2);
         push.entries[1].data = c8_next;
         push.entries[1].last = 1'b1;
      end else begin
         push.count = BURST_W'(4);
         push.entries[1].data = crc_hi;
         push.entries[2].data = crc_lo;
         push.entries[3].data = crc8_enable_ff ? c8_final : BYTE_ZERO;
         push.entries[3].last = 1'b1;
      end
      if (!accept) begin
         push.count = '0;
      end

      if (req_data_last) begin
         crc16_accum_in = crc16_init_ff;
         crc8_accum_in  = BYTE_ZERO;
         byte_index_in  = '0;
      end else begin
         crc16_accum_in = c16_next;
         crc8_accum_in  = c8_next;
         byte_index_in  = (byte_index_ff == INDEX_MAX) ? byte_index_ff : byte_index_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc8_accum_ff <= '0;
         byte_index_ff <= '0;
      end else if (accept) begin
         crc8_accum_ff <= crc8_accum_in;
         byte_index_ff <= byte_index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         crc16_accum_ff <= crc16_accum_in;
      end
   end

   rfct_out_queue u_out_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_ready   (req_ready),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

endmodule
`default_nettype wire

// ----- design/rfct_out_queue.sv -----
// Output queue that takes a burst of up to four frame bytes and hands them out one per transfer.
`default_nettype none
module rfct_out_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire rfct_pkg::rfct_push_type push,
   output logic                        push_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [rfct_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic                        rsp_out_last
);
   import rfct_pkg::*;

   rfct_entry_type [QUEUE_DEPTH-1:0] entry_ff;
   rfct_entry_type [QUEUE_DEPTH-1:0] entry_in;
   rfct_entry_type [QUEUE_DEPTH-1:0] shifted;
   logic [COUNT_W-1:0]               count_ff;
   logic [COUNT_W-1:0]               count_in;
   logic                             pop;
   logic [COUNT_W-1:0]               base;
   logic [COUNT_W-1:0]               rel;

   assign pop          = (count_ff != '0) && rsp_ready;
   assign rsp_valid    = (count_ff != '0);
   assign rsp_out_byte = entry_ff[0].data;
   assign rsp_out_last = entry_ff[0].last;
   assign push_ready   = (count_ff <= COUNT_W'(QUEUE_DEPTH - BURST_MAX));

   always_comb begin
      base     = count_ff - COUNT_W'(pop);
      count_in = base + COUNT_W'(push.count);
      shifted[QUEUE_DEPTH-1] = entry_ff[QUEUE_DEPTH-1];
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
         shifted[i] = entry_ff[i + 1];
      end
      entry_in = pop ? shifted : entry_ff;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         rel = COUNT_W'(i) - base;
         if ((COUNT_W'(i) >= base) && (rel < COUNT_W'(push.count))) begin
            entry_in[i] = push.entries[rel[BURST_W-2:0]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
`default_nettype wire

// ----- design/rfct_checker.sv -----
// Port-level assertions of the radio frame check trailer and their bind to the top level.
`default_nettype none
module rfct_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_valid,
   input wire logic                             req_ready,
   input wire logic [rfct_pkg::BYTE_W-1:0]      req_data_byte,
   input wire logic                             req_data_last,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic [rfct_pkg::BYTE_W-1:0]      rsp_out_byte,
   input wire logic                             rsp_out_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_out_last))
      else $error("rsp payload changed while the transfer was stalled");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   a_body_pass: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && req_valid && req_ready && !req_data_last
      |=> rsp_valid && rsp_out_byte == $past(req_data_byte) && !rsp_out_last)
      else $error("body byte not passed through on the next cycle");

   a_accept_shows: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && req_valid && req_ready |=> rsp_valid)
      else $error("accepted transfer produced no output");

   a_stall_keeps_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && !req_ready |=> !req_ready)
      else $error("req_ready rose with no output transfer");

endmodule

bind radio_frame_crc_trailer rfct_checker u_rfct_checker (.*);
`default_nettype wire

// ----- dv/tb_top.sv -----
// Testbench for the radio frame check trailer: directed table, random frames, predicted bytes.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rfct_pkg::*;

   localparam int DIR_N       = 25;
   localparam int RAND_ITEMS  = 330;
   localparam int STALL_LIMIT = 1000;
   localparam int DRAIN_WAIT  = 20;

   typedef struct packed {
      logic                   is_setting;
      logic                   en16;
      logic                   en8;
      logic [7:0]             offset;
      logic [15:0]            init;
      logic [7:0]             data;
      logic                   last;
      logic [0:3]             typed_mask;
      logic [0:3][8:0]        typed;
   } step_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [BYTE_W-1:0]      req_data_byte = '0;
   logic                   req_data_last = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [BYTE_W-1:0]      rsp_out_byte;
   logic                   rsp_out_last;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   logic [8:0]             frame_bytes_due[$];
   int                     errors = 0;
   int                     quiet_cycles = 0;
   bit                     send_fast = 1'b0;
   bit                     rsp_fast = 1'b0;

   logic                   cfg_en16;
   logic                   cfg_en8;
   logic [7:0]             cfg_offset;
   logic [15:0]            cfg_init;
   logic [15:0]            acc16;
   logic [7:0]             acc8;
   logic [7:0]             frame_idx;

   radio_frame_crc_trailer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_data_last    (req_data_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_out_last     (rsp_out_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #10ns clock = ~clock;

   function automatic step_row_type item_row(input logic [7:0] d, input logic l,
                                             input logic [0:3] m, input logic [35:0] t);
      step_row_type row;
      row = '0;
      row.data = d;
      row.last = l;
      row.typed_mask = m;
      row.typed = t;
      return row;
   endfunction

   function automatic step_row_type setting_row(input logic e16, input logic e8,
                                                input logic [7:0] off, input logic [15:0] ini);
      step_row_type row;
      row = '0;
      row.is_setting = 1'b1;
      row.en16 = e16;
      row.en8 = e8;
      row.offset = off;
      row.init = ini;
      return row;
   endfunction

   localparam step_row_type DIR_ROWS [DIR_N] = '{
      item_row(8'h00, 1'b1, 4'b1110, {8'h00, 1'b0, 8'hFF, 1'b0, 8'hFF, 1'b0, 9'h0}),
      item_row(8'hFF, 1'b0, 4'b1000, {8'hFF, 1'b0, 27'h0}),
      item_row(8'h55, 1'b1, 4'b1110, {8'h55, 1'b0, 8'hFF, 1'b0, 8'hFF, 1'b0, 9'h0}),
      setting_row(1'b1, 1'b1, 8'd0, 16'hFFFF),
      item_row(8'h00, 1'b0, 4'b1000, {8'h00, 1'b0, 27'h0}),
      item_row(8'hAA, 1'b0, 4'b1000, {8'hAA, 1'b0, 27'h0}),
      item_row(8'h01, 1'b1, 4'b1000, {8'h01, 1'b0, 27'h0}),
      setting_row(1'b0, 1'b1, 8'd0, 16'hFFFF),
      item_row(8'h80, 1'b1, 4'b1000, {8'h80, 1'b0, 27'h0}),
      item_row(8'h7F, 1'b0, 4'b1000, {8'h7F, 1'b0, 27'h0}),
      item_row(8'hFE, 1'b1, 4'b1000, {8'hFE, 1'b0, 27'h0}),
      setting_row(1'b0, 1'b0, 8'd0, 16'hFFFF),
      item_row(8'hFF, 1'b1, 4'b1000, {8'hFF, 1'b1, 27'h0}),
      item_row(8'h00, 1'b1, 4'b1000, {8'h00, 1'b1, 27'h0}),
      setting_row(1'b1, 1'b0, 8'd0, 16'hFFFF),
      item_row(8'h12, 1'b1, 4'b1001, {8'h12, 1'b0, 18'h0, 8'h00, 1'b1}),
      setting_row(1'b1, 1'b0, 8'hFF, 16'h0000),
      item_row(8'h3C, 1'b0, 4'b1000, {8'h3C, 1'b0, 27'h0}),
      item_row(8'hC3, 1'b0, 4'b1000, {8'hC3, 1'b0, 27'h0}),
      item_row(8'hF0, 1'b0, 4'b1000, {8'hF0, 1'b0, 27'h0}),
      item_row(8'h0F, 1'b0, 4'b1000, {8'h0F, 1'b0, 27'h0}),
      item_row(8'hA5, 1'b1, 4'b1111, {8'hA5, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b1}),
      setting_row(1'b1, 1'b1, 8'd1, 16'h1234),
      item_row(8'h01, 1'b0, 4'b1000, {8'h01, 1'b0, 27'h0}),
      item_row(8'hFE, 1'b1, 4'b1000, {8'hFE, 1'b0, 27'h0})
   };

   function automatic logic [15:0] fold_crc16(input logic [15:0] c, input logic [7:0] v);
      logic fb;
      for (int k = 0; k < 8; k++) begin
         fb = c[0] ^ v[k];
         c = c >> 1;
         if (fb) begin
            c = c ^ CRC16_POLY;
         end
      end
      return c;
   endfunction

   function automatic logic [7:0] fold_crc8(input logic [7:0] c, input logic [7:0] v);
      logic fb;
      for (int k = 7; k >= 0; k--) begin
         fb = c[7] ^ v[k];
         c = c << 1;
         if (fb) begin
            c = c ^ CRC8_TAPS;
         end
      end
      return c;
   endfunction

   task automatic predict_frame_bytes(input logic [7:0] d, input logic l, output int n,
                                      output logic [0:3][8:0] r);
      logic [15:0] c16;
      logic [7:0]  c8;
      c16 = (frame_idx == 8'd0) ? cfg_init : acc16;
      c8 = (frame_idx == 8'd0) ? 8'h00 : acc8;
      if (frame_idx >= cfg_offset) begin
         c16 = fold_crc16(c16, d);
      end
      c8 = fold_crc8(c8, d);
      r = '0;
      if (!l) begin
         r[0] = {d, 1'b0};
         n = 1;
         acc16 = c16;
         acc8 = c8;
         if (frame_idx != INDEX_MAX) begin
            frame_idx = frame_idx + 8'd1;
         end
      end else begin
         if (!cfg_en16 && !cfg_en8) begin
            r[0] = {d, 1'b1};
            n = 1;
         end else if (!cfg_en16) begin
            r[0] = {d, 1'b0};
            r[1] = {c8, 1'b1};
            n = 2;
         end else begin
            c8 = fold_crc8(fold_crc8(c8, c16[15:8]), c16[7:0]);
            r[0] = {d, 1'b0};
            r[1] = {c16[15:8], 1'b0};
            r[2] = {c16[7:0], 1'b0};
            r[3] = {(cfg_en8 ? c8 : 8'h00), 1'b1};
            n = 4;
         end
         acc16 = cfg_init;
         acc8 = 8'h00;
         frame_idx = 8'd0;
      end
   endtask

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_byte(input logic [7:0] d, input logic l, input logic [0:3] m,
                            input logic [0:3][8:0] t);
      int              n;
      int              gap;
      logic [0:3][8:0] r;
      predict_frame_bytes(d, l, n, r);
      for (int j = 0; j < n; j++) begin
         frame_bytes_due.push_back(m[j] ? t[j] : r[j]);
      end
      gap = send_fast ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= d;
      req_data_last <= l;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
   endtask

   // Waits until every predicted byte has come out, then writes all four registers.
   task automatic set_config(input logic e16, input logic e8, input logic [7:0] off,
                             input logic [15:0] ini);
      logic [15:0] noise;
      req_valid <= 1'b0;
      while (frame_bytes_due.size() != 0) @(negedge clock);
      noise = 16'($urandom);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_CRC16_ENABLE;
      csr_write_data <= {noise[15:1], e16};
      @(negedge clock);
      noise = 16'($urandom);
      csr_index <= CSR_CRC8_ENABLE;
      csr_write_data <= {noise[15:1], e8};
      @(negedge clock);
      noise = 16'($urandom);
      csr_index <= CSR_CRC16_OFFSET;
      csr_write_data <= {noise[15:8], off};
      @(negedge clock);
      csr_index <= CSR_CRC16_INIT;
      csr_write_data <= ini;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      cfg_en16 = e16;
      cfg_en8 = e8;
      cfg_offset = off;
      cfg_init = ini;
   endtask

   initial begin : rsp_side
      int stall;
      while (reset) @(negedge clock);
      forever begin
         stall = rsp_fast ? 0 : $urandom_range(0, 12);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   always @(posedge clock) begin : check_out
      logic [8:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (frame_bytes_due.size() == 0) begin
            if (errors < 10) begin
               $display("unexpected output byte %h last %b", rsp_out_byte, rsp_out_last);
            end
            errors++;
         end else begin
            want = frame_bytes_due.pop_front();
            if (rsp_out_byte !== want[8:1] || rsp_out_last !== want[0]) begin
               if (errors < 10) begin
                  $display("mismatch: byte %h last %b, expected byte %h last %b",
                           rsp_out_byte, rsp_out_last, want[8:1], want[0]);
               end
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin : stimulus
      int          rand_count;
      int          n_frames;
      int          len;
      bit          long_done;
      bit          long_phase;
      logic        e16;
      logic [7:0]  off;
      logic [15:0] ini;
      rand_count = 0;
      long_done = 1'b0;
      cfg_en16 = RESET_CRC16_ENABLE;
      cfg_en8 = RESET_CRC8_ENABLE;
      cfg_offset = RESET_CRC16_OFFSET;
      cfg_init = RESET_CRC16_INIT;
      acc16 = RESET_CRC16_INIT;
      acc8 = 8'h00;
      frame_idx = 8'd0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < DIR_N; i++) begin
         if (DIR_ROWS[i].is_setting) begin
            set_config(DIR_ROWS[i].en16, DIR_ROWS[i].en8, DIR_ROWS[i].offset,
                       DIR_ROWS[i].init);
         end else begin
            send_byte(DIR_ROWS[i].data, DIR_ROWS[i].last, DIR_ROWS[i].typed_mask,
                      DIR_ROWS[i].typed);
         end
      end

      while (rand_count < RAND_ITEMS) begin
         long_phase = !long_done && rand_count >= 60;
         case ($urandom_range(0, 4))
            0: begin
               off = 8'd0;
            end
            1: begin
               off = 8'hFF;
            end
            default: begin
               off = 8'($urandom_range(0, 12));
            end
         endcase
         case ($urandom_range(0, 3))
            0: begin
               ini = 16'h0000;
            end
            1: begin
               ini = 16'hFFFF;
            end
            default: begin
               ini = 16'($urandom);
            end
         endcase
         e16 = 1'($urandom_range(0, 1));
         if (long_phase) begin
            off = 8'hFF;
            e16 = 1'b1;
         end
         set_config(e16, 1'($urandom_range(0, 1)), off, ini);
         send_fast = ($urandom_range(0, 3) == 0);
         rsp_fast = ($urandom_range(0, 3) == 0);
         n_frames = long_phase ? 1 : $urandom_range(2, 6);
         repeat (n_frames) begin
            if (long_phase) begin
               len = 256 + $urandom_range(0, 8);
            end else if ($urandom_range(0, 4) == 0) begin
               len = $urandom_range(13, 24);
            end else begin
               len = $urandom_range(1, 12);
            end
            for (int k = 0; k < len; k++) begin
               send_byte(8'($urandom), (k == len - 1), 4'b0000, '0);
            end
            rand_count += len;
         end
         if (long_phase) begin
            long_done = 1'b1;
         end
      end

      req_valid <= 1'b0;
      while (frame_bytes_due.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
      if (errors == 0 && frame_bytes_due.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
